// ===== design/vn2c_pkg.sv =====
// shared types, constants and the cosine weight table for the 2-d value noise block
// no dependencies
package vn2c_pkg;

  localparam int FRAC_BITS = 8;
  localparam int INT_BITS  = 10;
  localparam int COORD_W   = 18;
  localparam int W_W       = 17;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;
  localparam int HGT_W     = 16;

  // one classified item: lattice cell and interpolation weights
  typedef struct packed {
    logic [INT_BITS-1:0] ix;
    logic [INT_BITS-1:0] iy;
    logic [W_W-1:0]      wx;
    logic [W_W-1:0]      wy;
  } pt_t;

  typedef logic [W_W-1:0] wrom_t [2**FRAC_BITS];

  // (1 - cos(pi*t))/2 for t in 0..1/2, Q0.16, truncated horner series in q30
  function automatic logic [W_W-1:0] half_weight(longint unsigned t16);
    longint unsigned u;
    longint unsigned uu;
    longint u2;
    longint h;
    longint c;
    longint w;
    u  = (t16 * 64'd3373259426) >> 16;
    uu = u * u;
    u2 = longint'(uu >> 30);
    h  = 64'sd1073741824 - u2 / 90;
    h  = 64'sd1073741824 - ((u2 * h) >>> 30) / 56;
    h  = 64'sd1073741824 - ((u2 * h) >>> 30) / 30;
    h  = 64'sd1073741824 - ((u2 * h) >>> 30) / 12;
    c  = 64'sd1073741824 - ((u2 * h) >>> 30) / 2;
    w  = 64'sd1073741824 - c;
    if (w < 0) w = 0;
    w = (w + 64'sd16384) >>> 15;
    if (w > 65536) w = 65536;
    return w[W_W-1:0];
  endfunction

  // full table over the fraction bits, mirrored about one half
  function automatic wrom_t build_wrom();
    wrom_t tab;
    longint unsigned t16;
    for (int i = 0; i < 2**FRAC_BITS; i++) begin
      t16 = longint'(i) << (16 - FRAC_BITS);
      if (t16 <= 32768) tab[i] = half_weight(t16);
      else tab[i] = W_W'(65536) - half_weight(65536 - t16);
    end
    return tab;
  endfunction

  localparam wrom_t WROM = build_wrom();

endpackage

// ===== design/vn2c_front.sv =====
// front end: splits coordinates into cell and fraction, looks up the weights
// depends on vn2c_pkg
module vn2c_front (
  input  logic [vn2c_pkg::COORD_W-1:0] x_coord,
  input  logic [vn2c_pkg::COORD_W-1:0] y_coord,
  output vn2c_pkg::pt_t                pt
);
  import vn2c_pkg::*;

  logic [31:0] x_ext;
  logic [31:0] y_ext;

  // bits above the coordinate width fall away in the part-selects
  assign x_ext = {{(32-COORD_W){1'b0}}, x_coord};
  assign y_ext = {{(32-COORD_W){1'b0}}, y_coord};

  always_comb begin
    pt.ix = x_ext[FRAC_BITS+INT_BITS-1:FRAC_BITS];
    pt.iy = y_ext[FRAC_BITS+INT_BITS-1:FRAC_BITS];
    pt.wx = WROM[x_ext[FRAC_BITS-1:0]];
    pt.wy = WROM[y_ext[FRAC_BITS-1:0]];
  end

endmodule

// ===== design/vn2c_queue.sv =====
// short item queue between the front end and the hash/blend pipeline
// depends on vn2c_pkg
module vn2c_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  vn2c_pkg::pt_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output vn2c_pkg::pt_t rd_data
);
  import vn2c_pkg::*;

  pt_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;
  logic           pop;

  assign wr_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== design/vn2c_back.sv =====
// back end: corner hashing and three cosine blends in an eight-stage pipeline
// depends on vn2c_pkg
module vn2c_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vn2c_pkg::pt_t                      in_pt,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vn2c_pkg::HGT_W-1:0]  out_height
);
  import vn2c_pkg::*;

  logic [8:1]        v_r;
  logic              en;
  logic [31:0]       n1_r [4];
  logic [31:0]       n2_r [4];
  logic [31:0]       p2_r [4];
  logic [31:0]       n3_r [4];
  logic [31:0]       q3_r [4];
  logic [31:0]       h4_r [4];
  logic signed [33:0] m5_r [4];
  logic signed [15:0] lo6_r, hi6_r;
  logic signed [33:0] ma7_r, mb7_r;
  logic signed [HGT_W-1:0] hgt8_r;
  logic [W_W-1:0]    wx_r [1:4];
  logic [W_W-1:0]    wy_r [1:6];

  logic [31:0]       cx [4];
  logic [31:0]       cy [4];
  logic [31:0]       nsum [4];
  logic signed [15:0] cv [4];
  logic signed [17:0] wxa, wxb, wya, wyb;
  logic signed [35:0] slo, shi, sout;

  // whole pipe advances unless the output is held
  assign en         = !v_r[8] || out_ready;
  assign in_ready   = en;
  assign out_valid  = v_r[8];
  assign out_height = hgt8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:1], in_valid};
    end
  end

  // corner lattice positions, neighbors not wrapped
  always_comb begin
    cx[0] = {{(32-INT_BITS){1'b0}}, in_pt.ix};
    cy[0] = {{(32-INT_BITS){1'b0}}, in_pt.iy};
    cx[1] = cx[0] + 32'd1;
    cy[1] = cy[0];
    cx[2] = cx[0];
    cy[2] = cy[0] + 32'd1;
    cx[3] = cx[1];
    cy[3] = cy[2];
    for (int k = 0; k < 4; k++) begin
      nsum[k] = cx[k] + cy[k] * 32'd57;
    end
  end

  // corner values and blend weights
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cv[k] = 16'sd16384 - $signed({1'b0, h4_r[k][30:16]});
    end
    wxb  = $signed({1'b0, wx_r[4]});
    wxa  = 18'sd65536 - wxb;
    wyb  = $signed({1'b0, wy_r[6]});
    wya  = 18'sd65536 - wyb;
    slo  = {{2{m5_r[0][33]}}, m5_r[0]} + {{2{m5_r[1][33]}}, m5_r[1]} + 36'sd32768;
    shi  = {{2{m5_r[2][33]}}, m5_r[2]} + {{2{m5_r[3][33]}}, m5_r[3]} + 36'sd32768;
    sout = {{2{ma7_r[33]}}, ma7_r} + {{2{mb7_r[33]}}, mb7_r} + 36'sd32768;
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        n1_r[k] <= (nsum[k] << 13) ^ nsum[k];
        n2_r[k] <= n1_r[k];
        p2_r[k] <= n1_r[k] * n1_r[k];
        n3_r[k] <= n2_r[k];
        q3_r[k] <= p2_r[k] * 32'd60493 + 32'd19990303;
        h4_r[k] <= (n3_r[k] * q3_r[k] + 32'd1376312589) & 32'h7fffffff;
      end
      m5_r[0] <= cv[0] * wxa;
      m5_r[1] <= cv[1] * wxb;
      m5_r[2] <= cv[2] * wxa;
      m5_r[3] <= cv[3] * wxb;
      lo6_r   <= 16'(slo >>> 16);
      hi6_r   <= 16'(shi >>> 16);
      ma7_r   <= lo6_r * wya;
      mb7_r   <= hi6_r * wyb;
      hgt8_r  <= HGT_W'(sout >>> 16);
      wx_r[1] <= in_pt.wx;
      wy_r[1] <= in_pt.wy;
      for (int s = 2; s <= 4; s++) wx_r[s] <= wx_r[s-1];
      for (int s = 2; s <= 6; s++) wy_r[s] <= wy_r[s-1];
    end
  end

  // checks
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_height >= -16'sd16384 && out_height <= 16'sd16384))
    else $error("height out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_height)))
    else $error("stalled result lost");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[7]) |=> out_valid)
    else $error("item dropped at last stage");

endmodule

// ===== design/value_noise_2d_cosine.sv =====
// top level of the cosine-interpolated 2-d value noise block
// depends on vn2c_pkg, vn2c_front, vn2c_queue, vn2c_back
//
// Takes one point per cycle while in_ready is high (x and y, 10 integer and 8
// fraction bits) and returns one signed Q1.14 height per point in input order.
// Sustained rate is one item per clock while the output is not held. Through an
// empty queue an accepted item is first written into the four-entry input queue,
// then moves through the eight hash and blend stages to the output. The three
// chained 32-bit multiplies per corner and the two blend multiply stages set the
// pipeline depth. A held output stalls the pipeline, and the queue keeps
// taking items until it is full.
module value_noise_2d_cosine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [vn2c_pkg::COORD_W-1:0]       in_x_coord,
  input  logic [vn2c_pkg::COORD_W-1:0]       in_y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vn2c_pkg::HGT_W-1:0]  out_height
);
  import vn2c_pkg::*;

  pt_t  fr_pt;
  pt_t  q_pt;
  logic q_valid;
  logic q_ready;

  // classify
  vn2c_front u_front (
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .pt      (fr_pt)
  );

  // decouple
  vn2c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (fr_pt),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_pt)
  );

  // hash and blend
  vn2c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_pt      (q_pt),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_height (out_height)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for value_noise_2d_cosine: random and directed points, heights checked
// against an in-bench fixed point predictor; depends on vn2c_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import vn2c_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] in_x_coord = '0;
  logic [COORD_W-1:0] in_y_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [HGT_W-1:0] out_height;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  point_t point_q[$];
  logic signed [HGT_W-1:0] height_q[$];
  int mismatches = 0;
  int heights_seen = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  value_noise_2d_cosine dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // lattice corner value from the integer hash
  function automatic longint corner_val(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] n;
    logic [31:0] h;
    n = cx + cy * 32'd57;
    n = (n << 13) ^ n;
    h = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
    return 64'sd16384 - longint'(h >> 16);
  endfunction

  // cosine weight over the rising half, q0.16
  function automatic longint rise_weight(longint t16);
    longint unsigned ang;
    longint sq, acc, w;
    ang = (longint'(t16) * 64'd3373259426) >> 16;
    sq = longint'((ang * ang) >> 30);
    acc = 64'sd1073741824 - sq / 90;
    acc = 64'sd1073741824 - ((sq * acc) >>> 30) / 56;
    acc = 64'sd1073741824 - ((sq * acc) >>> 30) / 30;
    acc = 64'sd1073741824 - ((sq * acc) >>> 30) / 12;
    acc = 64'sd1073741824 - ((sq * acc) >>> 30) / 2;
    w = 64'sd1073741824 - acc;
    if (w < 0) w = 0;
    w = (w + 64'sd16384) >>> 15;
    if (w > 65536) w = 65536;
    return w;
  endfunction

  function automatic longint frac_weight(logic [FRAC_BITS-1:0] f);
    longint t16;
    t16 = longint'(f) << (16 - FRAC_BITS);
    if (t16 <= 32768) return rise_weight(t16);
    return 65536 - rise_weight(65536 - t16);
  endfunction

  // weighted mix rounded, then floored
  function automatic longint mix(longint a, longint b, longint w);
    longint v;
    v = a * (65536 - w) + b * w + 32768;
    return v >>> 16;
  endfunction

  function automatic logic signed [HGT_W-1:0] noise_height(point_t p);
    logic [31:0] ix, iy;
    longint wx, wy, lo, hi;
    ix = 32'(p.x >> FRAC_BITS);
    iy = 32'(p.y >> FRAC_BITS);
    wx = frac_weight(p.x[FRAC_BITS-1:0]);
    wy = frac_weight(p.y[FRAC_BITS-1:0]);
    lo = mix(corner_val(ix, iy), corner_val(ix + 1, iy), wx);
    hi = mix(corner_val(ix, iy + 1), corner_val(ix + 1, iy + 1), wx);
    return HGT_W'(mix(lo, hi, wy));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return COORD_W'($urandom_range(0, 3)) << FRAC_BITS;
      2: return {{INT_BITS{1'b1}}, FRAC_BITS'($urandom)};
      3: return {INT_BITS'($urandom), 8'h80};
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // append one point to the pending stimulus
  function automatic void queue_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    point_q.insert(point_q.size(), p);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_valid) begin
        height_q.insert(height_q.size(), noise_height('{x: in_x_coord, y: in_y_coord}));
      end
      if (point_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        point_t p;
        p = point_q.pop_front();
        in_valid <= 1'b1;
        in_x_coord <= p.x;
        in_y_coord <= p.y;
      end else begin
        in_valid <= 1'b0;
        if (point_q.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= calm || $urandom_range(0, 99) >= 12;
      if (out_valid && out_ready) begin
        heights_seen++;
        if (height_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected height %0d", out_height);
        end else begin
          logic signed [HGT_W-1:0] want;
          want = height_q.pop_front();
          if (want !== out_height) begin
            mismatches++;
            if (mismatches <= 10)
              $display("height mismatch: expected %0d got %0d", want, out_height);
          end
        end
      end
    end
  end

  initial begin
    // corners of the range, zero and half fractions, top lattice edge
    queue_point('0, '0);
    queue_point('1, '1);
    queue_point('1, '0);
    queue_point('0, '1);
    queue_point(18'h3ff00, 18'h3ff00);
    queue_point(18'h3ff80, 18'h00080);
    queue_point(18'h00001, 18'h000ff);
    queue_point(18'h2aaaa, 18'h15555);
    queue_point(18'h15555, 18'h2aaaa);
    queue_point(18'h00100, 18'h3ff7f);
    queue_point(18'h00081, 18'h0007f);
    for (int i = 0; i < 1750; i++) begin
      queue_point(rand_coord(), rand_coord());
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // stretch with random idling, then a stretch with no idling
    repeat (300) @(posedge clk);
    calm <= 1'b1;
    repeat (400) @(posedge clk);
    calm <= 1'b0;
    wait (stim_done && !in_valid && height_q.size() == 0);
    repeat (30) @(posedge clk);
    $display("ran %0d points through the noise block, %0d heights checked",
             1761, heights_seen);
    if (mismatches == 0 && height_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/vn2c_pkg.sv
design/vn2c_front.sv
design/vn2c_queue.sv
design/vn2c_back.sv
design/value_noise_2d_cosine.sv
dv/tb.sv
